// ===== sv/ctrma_pkg.sv =====
package ctrma_pkg;

  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 15;
  localparam int OFF_W    = 15;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MISALIGNED = 3'd1;
  localparam logic [2:0] ST_CROSSES    = 3'd2;
  localparam logic [2:0] ST_NO_REGION  = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BYTES = 2'd3;

  localparam logic [LEN_W-1:0] REGION_BYTES_RST = 15'd16384;

  typedef struct packed {
    logic [2:0]       status;
    logic             hit;       // access goes to a store word range
    logic             code_sel;  // 1: code store, 0: data store
    logic             load_ok;   // code load that writes
    logic [OFF_W-1:0] offset;    // byte offset inside the region
  } dec_t;

  function automatic logic [DATA_W-1:0] size_mask(input logic [2:0] size);
    logic [DATA_W-1:0] m;
    case (size)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd4:    m = 32'hffff_ffff;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/ctrma_if.sv =====
interface ctrma_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic [ctrma_pkg::ADDR_W-1:0] address;
  logic [2:0]                   access_size;
  logic [ctrma_pkg::DATA_W-1:0] write_data;

  modport source(output valid, operation, address, access_size, write_data, input ready);
  modport sink(input valid, operation, address, access_size, write_data, output ready);
endinterface

interface ctrma_res_if;
  logic                         valid;
  logic                         ready;
  logic [ctrma_pkg::DATA_W-1:0] read_data;
  logic [2:0]                   status;
  logic                         from_code;

  modport source(output valid, read_data, status, from_code, input ready);
  modport sink(input valid, read_data, status, from_code, output ready);
endinterface

// ===== sv/ctrma_store.sv =====
module ctrma_store #(
  parameter int WORDS = 4096
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] addr,
  input  logic [ctrma_pkg::DATA_W-1:0]               wdata,
  output logic [ctrma_pkg::DATA_W-1:0]               rdata_r
);

  logic [ctrma_pkg::DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

// ===== sv/ctrma_decode.sv =====
module ctrma_decode #(
  parameter int DATA_WORDS = 4096,
  parameter int CODE_WORDS = 4096
) (
  input  logic [1:0]                    operation,
  input  logic [ctrma_pkg::ADDR_W-1:0]  address,
  input  logic [2:0]                    access_size,
  input  logic [ctrma_pkg::ADDR_W-1:0]  data_origin,
  input  logic [ctrma_pkg::LEN_W-1:0]   data_bytes,
  input  logic [ctrma_pkg::ADDR_W-1:0]  code_origin,
  input  logic [ctrma_pkg::LEN_W-1:0]   code_bytes,
  output ctrma_pkg::dec_t               dec
);

  localparam logic [31:0] DCAP = 32'(DATA_WORDS * 4);
  localparam logic [31:0] CCAP = 32'(CODE_WORDS * 4);
  localparam logic [31:0] CWORDS = 32'(CODE_WORDS);

  logic [31:0] d_len, c_len, d_eff, c_eff, d_off, c_off, size32;
  logic        d_in, c_in, d_cross, c_cross, size_ok, aligned;

  always_comb begin
    d_len  = {{(32-ctrma_pkg::LEN_W){1'b0}}, data_bytes};
    c_len  = {{(32-ctrma_pkg::LEN_W){1'b0}}, code_bytes};
    d_eff  = (d_len < DCAP) ? d_len : DCAP;
    c_eff  = (c_len < CCAP) ? c_len : CCAP;
    d_off  = address - data_origin;
    c_off  = address - code_origin;
    size32 = {29'd0, access_size};
    d_in    = (address >= data_origin) && (d_off < d_eff);
    c_in    = (address >= code_origin) && (c_off < c_eff);
    d_cross = (d_off + size32) > d_eff;
    c_cross = (c_off + size32) > c_eff;
    size_ok = access_size inside {3'd1, 3'd2, 3'd4};
    aligned = (address[1:0] & (access_size[1:0] - 2'd1)) == 2'd0;

    dec = '0;
    dec.status = ctrma_pkg::ST_OK;
    case (operation)
      ctrma_pkg::OP_LOAD: begin
        if (address < CWORDS) begin
          dec.load_ok = 1'b1;
        end else begin
          dec.status = ctrma_pkg::ST_NO_REGION;
        end
      end
      ctrma_pkg::OP_READ, ctrma_pkg::OP_WRITE: begin
        if (!size_ok) begin
          dec.status = ctrma_pkg::ST_BAD_SIZE;
        end else if (!aligned) begin
          dec.status = ctrma_pkg::ST_MISALIGNED;
        end else if (d_in) begin
          // a read that starts in data never falls through to code
          if (d_cross) begin
            dec.status = ctrma_pkg::ST_CROSSES;
          end else begin
            dec.hit    = 1'b1;
            dec.offset = d_off[ctrma_pkg::OFF_W-1:0];
          end
        end else if (operation == ctrma_pkg::OP_READ && c_in) begin
          if (c_cross) begin
            dec.status = ctrma_pkg::ST_CROSSES;
          end else begin
            dec.hit      = 1'b1;
            dec.code_sel = 1'b1;
            dec.offset   = c_off[ctrma_pkg::OFF_W-1:0];
          end
        end else begin
          dec.status = ctrma_pkg::ST_NO_REGION;
        end
      end
      default: begin
        dec.status = ctrma_pkg::ST_NO_REGION;
      end
    endcase
  end

endmodule

// ===== sv/checked_two_region_memory_access.sv =====
// Channel  | Dir | Payload
// in_req   | in  | operation, address, access_size, write_data
// out_res  | out | read_data, status, from_code
// cfg_*    | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// A request that fails a check or is a code load goes from decode straight to done; a
// read in one word reads its word first, and a write (read-modify-write) then writes
// it back; straddling a word border adds a second read and, for a write, a second write,
// as each store has a single port. After reset both stores are swept to zero, one word a
// cycle, with no request taken. A finished result waits in the output register; a
// stalled output holds back the next result only once that one is ready to be loaded.
module checked_two_region_memory_access #(
  parameter int DATA_WORDS = 4096,
  parameter int CODE_WORDS = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  ctrma_req_if.sink                             in_req,
  ctrma_res_if.source                           out_res,
  input  logic                                  cfg_we,
  input  logic [ctrma_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ctrma_pkg::DATA_W-1:0]          cfg_wdata
);

  localparam int DAW  = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int CAW  = (CODE_WORDS > 1) ? $clog2(CODE_WORDS) : 1;
  localparam int MAXW = (DATA_WORDS > CODE_WORDS) ? DATA_WORDS : CODE_WORDS;
  localparam int IW   = (MAXW > 1) ? $clog2(MAXW) : 1;
  localparam logic [IW:0]   DW_CNT   = (IW+1)'(DATA_WORDS);
  localparam logic [IW:0]   CW_CNT   = (IW+1)'(CODE_WORDS);
  localparam logic [IW-1:0] CLR_LAST = IW'(MAXW - 1);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_RD0    = 9'b000001000,
    S_RD1    = 9'b000010000,
    S_RD2    = 9'b000100000,
    S_WR0    = 9'b001000000,
    S_WR1    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [IW-1:0] clr_r, clr_nxt;

  logic [ctrma_pkg::ADDR_W-1:0] data_origin_r, code_origin_r;
  logic [ctrma_pkg::LEN_W-1:0]  data_bytes_r, code_bytes_r;

  logic [1:0]                   op_r;
  logic [ctrma_pkg::ADDR_W-1:0] addr_r;
  logic [2:0]                   size_r;
  logic [ctrma_pkg::DATA_W-1:0] wdata_r;
  ctrma_pkg::dec_t              dec, dec_r;
  logic [ctrma_pkg::DATA_W-1:0] word0_r, word1_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [ctrma_pkg::DATA_W-1:0] out_data_r;
  logic [2:0]                   out_status_r;
  logic                         out_code_r;

  logic                         d_we, c_we;
  logic [DAW-1:0]               d_addr, d_w0, d_w1;
  logic [CAW-1:0]               c_addr, c_w0, c_w1;
  logic [ctrma_pkg::DATA_W-1:0] d_wdata, c_wdata, d_q, c_q, mem_q;

  logic [1:0]                   lane;
  logic                         span, second, is_write, load_out;
  logic [63:0]                  old64, bm64, wd64, new64, rd64;
  logic [ctrma_pkg::DATA_W-1:0] rd_val;

  ctrma_decode #(
    .DATA_WORDS(DATA_WORDS),
    .CODE_WORDS(CODE_WORDS)
  ) u_decode (
    .operation  (op_r),
    .address    (addr_r),
    .access_size(size_r),
    .data_origin(data_origin_r),
    .data_bytes (data_bytes_r),
    .code_origin(code_origin_r),
    .code_bytes (code_bytes_r),
    .dec        (dec)
  );

  ctrma_store #(.WORDS(DATA_WORDS)) u_data_store (
    .clk    (clk),
    .we     (d_we),
    .addr   (d_addr),
    .wdata  (d_wdata),
    .rdata_r(d_q)
  );

  ctrma_store #(.WORDS(CODE_WORDS)) u_code_store (
    .clk    (clk),
    .we     (c_we),
    .addr   (c_addr),
    .wdata  (c_wdata),
    .rdata_r(c_q)
  );

  // byte lane handling over the two words an access can touch
  always_comb begin
    lane     = dec_r.offset[1:0];
    span     = ({2'b00, lane} + {1'b0, size_r}) > 4'd4;
    is_write = op_r == ctrma_pkg::OP_WRITE;
    second   = (state_r == S_RD1) || (state_r == S_WR1);
    d_w0     = DAW'(dec_r.offset >> 2);
    d_w1     = d_w0 + DAW'(1);
    c_w0     = CAW'(dec_r.offset >> 2);
    c_w1     = c_w0 + CAW'(1);
    mem_q    = dec_r.code_sel ? c_q : d_q;
    old64    = {word1_r, word0_r};
    bm64     = {32'd0, ctrma_pkg::size_mask(size_r)} << {lane, 3'b000};
    wd64     = {32'd0, wdata_r} << {lane, 3'b000};
    new64    = (old64 & ~bm64) | (wd64 & bm64);
    rd64     = old64 >> {lane, 3'b000};
    rd_val   = rd64[31:0] & ctrma_pkg::size_mask(size_r);
  end

  always_comb begin
    d_we    = 1'b0;
    c_we    = 1'b0;
    d_addr  = second ? d_w1 : d_w0;
    c_addr  = second ? c_w1 : c_w0;
    d_wdata = second ? new64[63:32] : new64[31:0];
    c_wdata = wdata_r;
    case (state_r)
      S_CLEAR: begin
        d_we    = {1'b0, clr_r} < DW_CNT;
        c_we    = {1'b0, clr_r} < CW_CNT;
        d_addr  = DAW'(clr_r);
        c_addr  = CAW'(clr_r);
        d_wdata = '0;
        c_wdata = '0;
      end
      S_DECODE: begin
        c_we   = dec.load_ok;
        c_addr = CAW'(addr_r);
      end
      S_WR0, S_WR1: begin
        d_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    load_out  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + IW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_req.valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = dec.hit ? S_RD0 : S_DONE;
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        if (span) begin
          state_nxt = S_RD2;
        end else begin
          state_nxt = is_write ? S_WR0 : S_DONE;
        end
      end
      S_RD2: begin
        state_nxt = is_write ? S_WR0 : S_DONE;
      end
      S_WR0: begin
        state_nxt = span ? S_WR1 : S_DONE;
      end
      S_WR1: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_res.ready) || load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
      data_origin_r <= '0;
      data_bytes_r  <= ctrma_pkg::REGION_BYTES_RST;
      code_origin_r <= '0;
      code_bytes_r  <= ctrma_pkg::REGION_BYTES_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ctrma_pkg::CFG_DATA_BASE:  data_origin_r <= cfg_wdata;
          ctrma_pkg::CFG_DATA_BYTES: data_bytes_r  <= cfg_wdata[ctrma_pkg::LEN_W-1:0];
          ctrma_pkg::CFG_CODE_BASE:  code_origin_r <= cfg_wdata;
          ctrma_pkg::CFG_CODE_BYTES: code_bytes_r  <= cfg_wdata[ctrma_pkg::LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_req.valid) begin
      op_r    <= in_req.operation;
      addr_r  <= in_req.address;
      size_r  <= in_req.access_size;
      wdata_r <= in_req.write_data;
    end
    if (state_r == S_DECODE) begin
      dec_r <= dec;
    end
    if (state_r == S_RD1) begin
      word0_r <= mem_q;
    end
    if (state_r == S_RD2) begin
      word1_r <= mem_q;
    end
    if (load_out) begin
      out_status_r <= dec_r.status;
      if (dec_r.hit && op_r == ctrma_pkg::OP_READ) begin
        out_data_r <= rd_val;
        out_code_r <= dec_r.code_sel;
      end else begin
        out_data_r <= '0;
        out_code_r <= 1'b0;
      end
    end
  end

  assign in_req.ready      = state_r == S_IDLE;
  assign out_res.valid     = out_valid_r;
  assign out_res.read_data = out_data_r;
  assign out_res.status    = out_status_r;
  assign out_res.from_code = out_code_r;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ctrma_pkg::*;

  localparam int MEM_WORDS  = 4096;
  localparam int REGION_CAP = MEM_WORDS * 4;

  typedef enum int {DEC_MISS, DEC_HIT, DEC_CROSS} decode_t;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic [2:0]        status;
    logic              from_code;
  } access_result_t;

  class region_scoreboard;
    logic [31:0]      data_words [MEM_WORDS];
    logic [31:0]      code_words [MEM_WORDS];
    logic [31:0]      data_origin;
    logic [LEN_W-1:0] data_bytes;
    logic [31:0]      code_origin;
    logic [LEN_W-1:0] code_bytes;
    access_result_t   expected_q [$];
    int               errors;
    int               requests;
    int               status_seen [5];
    int               code_reads;

    function new();
      foreach (data_words[i]) data_words[i] = '0;
      foreach (code_words[i]) code_words[i] = '0;
      data_origin = '0;
      data_bytes  = REGION_BYTES_RST;
      code_origin = '0;
      code_bytes  = REGION_BYTES_RST;
      errors      = 0;
      requests    = 0;
      code_reads  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        CFG_DATA_BASE:  data_origin = value;
        CFG_DATA_BYTES: data_bytes  = value[LEN_W-1:0];
        CFG_CODE_BASE:  code_origin = value;
        CFG_CODE_BYTES: code_bytes  = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function decode_t decode(logic [31:0] addr, int size, logic [31:0] base,
                             logic [LEN_W-1:0] bytes, output int off);
      longint o;
      int     eff;
      off = 0;
      eff = (bytes > REGION_CAP) ? REGION_CAP : int'(bytes);
      if (addr < base) return DEC_MISS;
      o = addr - base;
      if (o >= eff) return DEC_MISS;
      if (o + size > eff) return DEC_CROSS;
      off = int'(o);
      return DEC_HIT;
    endfunction

    function logic [31:0] fetch(bit code_mem, int off, int size);
      logic [31:0] v;
      logic [31:0] w;
      int          b;
      v = '0;
      for (int i = 0; i < size; i++) begin
        b = off + i;
        if ((b >> 2) < MEM_WORDS) begin
          w = code_mem ? code_words[b >> 2] : data_words[b >> 2];
          v[8*i +: 8] = w[8*(b % 4) +: 8];
        end
      end
      return v;
    endfunction

    function void store(int off, int size, logic [31:0] value);
      int b;
      for (int i = 0; i < size; i++) begin
        b = off + i;
        if ((b >> 2) < MEM_WORDS)
          data_words[b >> 2][8*(b % 4) +: 8] = value[8*i +: 8];
      end
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] addr, logic [2:0] size,
                               logic [31:0] wdata);
      access_result_t r;
      decode_t        d;
      int             off;
      r.read_data = '0;
      r.status    = ST_OK;
      r.from_code = 1'b0;
      if (op == OP_LOAD) begin
        if (addr < MEM_WORDS) code_words[addr] = wdata;
        else r.status = ST_NO_REGION;
      end else if (op == OP_NONE) begin
        r.status = ST_NO_REGION;
      end else if (!(size inside {3'd1, 3'd2, 3'd4})) begin
        r.status = ST_BAD_SIZE;
      end else if (addr % size != 0) begin
        r.status = ST_MISALIGNED;
      end else begin
        d = decode(addr, size, data_origin, data_bytes, off);
        if (d == DEC_CROSS) begin
          r.status = ST_CROSSES;
        end else if (d == DEC_HIT) begin
          if (op == OP_READ) r.read_data = fetch(1'b0, off, size);
          else store(off, size, wdata);
        end else if (op == OP_READ) begin
          // data region missed: reads fall through to the code region
          d = decode(addr, size, code_origin, code_bytes, off);
          if (d == DEC_CROSS) begin
            r.status = ST_CROSSES;
          end else if (d == DEC_HIT) begin
            r.read_data = fetch(1'b1, off, size);
            r.from_code = 1'b1;
          end else begin
            r.status = ST_NO_REGION;
          end
        end else begin
          r.status = ST_NO_REGION;
        end
      end
      expected_q.push_back(r);
      requests++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(logic [31:0] rdata, logic [2:0] status, logic from_code);
      access_result_t e;
      if (expected_q.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = expected_q.pop_front();
      if (rdata !== e.read_data)
        report($sformatf("read_data %h, expected %h", rdata, e.read_data));
      if (status !== e.status)
        report($sformatf("status %0d, expected %0d", status, e.status));
      if (from_code !== e.from_code)
        report($sformatf("from_code %b, expected %b", from_code, e.from_code));
      if (e.status < 5) status_seen[e.status]++;
      if (e.from_code) code_reads++;
    endtask

    task check_leftovers();
      if (expected_q.size() != 0)
        report($sformatf("%0d expected results never arrived", expected_q.size()));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  ctrma_req_if in_req ();
  ctrma_res_if out_res ();

  checked_two_region_memory_access #(
    .DATA_WORDS(MEM_WORDS),
    .CODE_WORDS(MEM_WORDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  region_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold-off counted here
  initial begin
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_res.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_res.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_req.valid && in_req.ready)
      sb.note_request(in_req.operation, in_req.address, in_req.access_size,
                      in_req.write_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready)
      sb.check_result(out_res.read_data, out_res.status, out_res.from_code);
  end

  task automatic send_request(input logic [1:0] op, input logic [31:0] addr,
                              input logic [2:0] size, input logic [31:0] wdata);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.operation   <= op;
    in_req.address     <= addr;
    in_req.access_size <= size;
    in_req.write_data  <= wdata;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic program_regions(input logic [31:0] dbase, input logic [31:0] dbytes,
                                 input logic [31:0] cbase, input logic [31:0] cbytes);
    write_reg(CFG_DATA_BASE, dbase);
    write_reg(CFG_DATA_BYTES, dbytes);
    write_reg(CFG_CODE_BASE, cbase);
    write_reg(CFG_CODE_BYTES, cbytes);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results(input int settle);
    int waited;
    waited = 0;
    in_req.valid <= 1'b0;
    // let the last accepted request reach the scoreboard first
    @(posedge clk);
    while (sb.pending() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  function automatic int eff_len(logic [LEN_W-1:0] b);
    return (b > REGION_CAP) ? REGION_CAP : int'(b);
  endfunction

  task automatic send_random(input int count);
    logic [1:0]  op;
    logic [2:0]  size;
    logic [31:0] addr;
    int          pick;
    int          deff;
    int          ceff;
    deff = eff_len(sb.data_bytes);
    ceff = eff_len(sb.code_bytes);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45)      op = OP_READ;
      else if (pick < 72) op = OP_WRITE;
      else if (pick < 96) op = OP_LOAD;
      else                op = OP_NONE;
      if ($urandom_range(9) < 8) begin
        case ($urandom_range(2))
          0:       size = 3'd1;
          1:       size = 3'd2;
          default: size = 3'd4;
        endcase
      end else begin
        size = 3'($urandom_range(7));
      end
      pick = $urandom_range(99);
      if (op == OP_LOAD) begin
        // word indexes that code reads will land on, a few out of range
        if (pick < 90)      addr = $urandom_range(0, ceff / 4 + 1);
        else if (pick < 95) addr = $urandom_range(0, MEM_WORDS - 1);
        else                addr = $urandom();
      end else begin
        if (pick < 50)      addr = sb.data_origin + $urandom_range(0, deff + 7);
        else if (pick < 85) addr = sb.code_origin + $urandom_range(0, ceff + 7);
        else if (pick < 90) addr = sb.data_origin - $urandom_range(1, 8);
        else                addr = $urandom();
        if ($urandom_range(9) < 8 && size inside {3'd1, 3'd2, 3'd4})
          addr = addr & ~(32'(size) - 32'd1);
      end
      send_request(op, addr, size, $urandom());
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_req.valid       <= 1'b0;
    in_req.operation   <= OP_READ;
    in_req.address     <= '0;
    in_req.access_size <= '0;
    in_req.write_data  <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_DATA_BASE;
    cfg_wdata          <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 17;
    recv_idle_pct = 82;

    // data region ends mid-word so an aligned word access can cross it
    program_regions(32'h0000_1000, 32'd254, 32'h0000_2000, 32'd256);
    send_request(OP_WRITE, 32'h0000_1000, 3'd4, 32'hDEAD_BEEF);
    send_request(OP_READ,  32'h0000_1000, 3'd4, 32'h0);
    send_request(OP_READ,  32'h0000_1001, 3'd1, 32'h0);
    send_request(OP_READ,  32'h0000_1002, 3'd2, 32'h0);
    send_request(OP_WRITE, 32'h0000_1003, 3'd1, 32'hFFFF_FFA5);
    send_request(OP_READ,  32'h0000_1000, 3'd4, 32'h0);
    send_request(OP_WRITE, 32'h0000_1002, 3'd4, 32'h1234_5678);
    send_request(OP_READ,  32'h0000_1000, 3'd0, 32'h0);
    send_request(OP_READ,  32'h0000_1001, 3'd3, 32'h0);
    send_request(OP_WRITE, 32'h0000_1000, 3'd7, 32'hFFFF_FFFF);
    send_request(OP_READ,  32'h0000_10FC, 3'd4, 32'h0);
    send_request(OP_READ,  32'h0000_10FC, 3'd2, 32'h0);
    send_request(OP_READ,  32'h0000_10FE, 3'd2, 32'h0);
    send_request(OP_LOAD,  32'd0,         3'd0, 32'h1122_3344);
    send_request(OP_LOAD,  32'd4095,      3'd5, 32'hCAFE_F00D);
    send_request(OP_LOAD,  32'd4096,      3'd4, 32'h5555_5555);
    send_request(OP_LOAD,  32'hFFFF_FFFF, 3'd4, 32'hAAAA_AAAA);
    send_request(OP_READ,  32'h0000_2000, 3'd4, 32'h0);
    send_request(OP_READ,  32'h0000_2003, 3'd1, 32'h0);
    send_request(OP_READ,  32'h0000_20FC, 3'd4, 32'h0);
    send_request(OP_WRITE, 32'h0000_2000, 3'd4, 32'h0BAD_0BAD);
    send_request(OP_READ,  32'h0000_0FFF, 3'd1, 32'h0);
    send_request(OP_READ,  32'hFFFF_FFFC, 3'd4, 32'h0);
    send_request(OP_NONE,  32'h0000_1000, 3'd4, 32'hFFFF_FFFF);
    drain_results(8);

    program_regions(32'h0000_1000, 32'd256, 32'h0000_2000, 32'd512);
    send_random(160);
    drain_results(8);

    // full-size data region at the top of the address space, empty code region
    program_regions(32'hFFFF_C000, 32'd16384, 32'h0000_0000, 32'd0);
    send_random(170);
    drain_results(8);

    send_idle_pct = 82;
    recv_idle_pct = 17;

    // unaligned bases; upper bits of the length write are dropped, rest clipped
    program_regions(32'h0000_0102, 32'd64, 32'h0000_4003, 32'h0001_7FFF);
    send_random(170);
    drain_results(8);

    program_regions(32'h0000_0100, 32'd0, 32'h0000_0000, 32'd16384);
    send_random(170);
    drain_results(8);

    send_idle_pct = 0;
    recv_idle_pct = 0;

    program_regions(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FF00, 32'd16384);
    send_random(90);
    hold_cycles = 400;
    send_random(90);
    drain_results(0);
    send_random(90);
    drain_results(20);

    sb.check_leftovers();
    $display("Ran %0d requests across six region layouts, idle mixes and a long output stall",
             sb.requests);
    $display("Status ok/misaligned/crossing/no-region/bad-size = %0d/%0d/%0d/%0d/%0d, code reads %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_MISALIGNED], sb.status_seen[ST_CROSSES],
             sb.status_seen[ST_NO_REGION], sb.status_seen[ST_BAD_SIZE], sb.code_reads);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ctrma_pkg.sv
sv/ctrma_if.sv
sv/ctrma_store.sv
sv/ctrma_decode.sv
sv/checked_two_region_memory_access.sv
dv/tb.sv
